/* sv/eight_bit_alu_with_flags_assert.svh */
// Assertion macros used by the ALU top file.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH

// Checked on every edge outside reset.
`define EALU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define EALU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ealu_pkg.sv */
`timescale 1ns / 1ps

package ealu_pkg;

	// Operation codes
	typedef enum logic [3:0] {
		OP_ADC = 4'd0,
		OP_SBC = 4'd1,
		OP_AND = 4'd2,
		OP_ORA = 4'd3,
		OP_EOR = 4'd4,
		OP_BIT = 4'd5,
		OP_CMP = 4'd6,
		OP_CPX = 4'd7,
		OP_CPY = 4'd8,
		OP_ASL = 4'd9,
		OP_LSR = 4'd10,
		OP_ROL = 4'd11,
		OP_ROR = 4'd12,
		OP_LDA = 4'd13,
		OP_LDX = 4'd14,
		OP_LDY = 4'd15
	} opcode_t;

	localparam logic [7:0] BYTE_ZERO = 8'h00;

	// Input beat
	typedef struct packed {
		logic [3:0] opcode;
		logic [7:0] operand;
	} req_t;

	// Result beat
	typedef struct packed {
		logic [7:0] result_byte;
		logic       carry_out;
		logic       zero_out;
		logic       overflow_out;
		logic       negative_out;
	} rsp_t;

	// Architectural registers and flags
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic       c;
		logic       z;
		logic       v;
		logic       n;
	} arch_t;

endpackage

/* sv/eight_bit_alu_with_flags.sv */
`timescale 1ns / 1ps
// 6502-style ALU with A, X, Y and the C, Z, V, N flags.
// Input channel req (req_valid/req_ready) carries one beat: a 4-bit opcode
// and an 8-bit operand. Output channel rsp (rsp_valid/rsp_ready) returns one
// beat per input: the produced byte and the four flags after the operation.
// Path: an accepted beat is held in the input register, executes against
// the current registers and flags, and then moves to the result register.
// Throughput: one beat per cycle while rsp_ready is high. The execute step
// is a single 8-bit add or subtract plus selection, and its result feeds
// A, X, Y and the flags back in the same cycle, so consecutive beats chain
// without bubbles.
// Reset (arst_n low, asynchronous): A, X, Y and all flags clear to zero and
// both pipeline registers empty.
// Receiver stall: the result register holds its beat while rsp_ready is low;
// the input register still takes one more beat, after which req_ready drops
// until the result is taken. No beat is dropped or repeated.
module eight_bit_alu_with_flags import ealu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	`include "eight_bit_alu_with_flags_assert.svh"

	logic  s1_valid_q;
	req_t  s1_q;
	logic  out_valid_q;
	rsp_t  out_q;
	logic  adv;
	arch_t cur;
	arch_t nxt;
	rsp_t  res;

	// Stage advances when the result register is free or being drained
	assign adv       = s1_valid_q && (!out_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			s1_q <= req;
		end
	end

	ealu_exec u_exec (
		.cur  (cur),
		.item (s1_q),
		.nxt  (nxt),
		.res  (res)
	);

	ealu_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.nxt    (nxt),
		.cur    (cur)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Checks
	`EALU_ASSERT(a_s1_hold, s1_valid_q && !adv |=> s1_valid_q && $stable(s1_q), "input beat lost")
	`EALU_ASSERT(a_state_hold, !adv |=> $stable(cur), "state changed without a beat")
	`EALU_ASSERT(a_adv_result, adv |=> out_valid_q, "executed beat gave no result")
	`EALU_ASSERT_ALWAYS(a_ready_free, !out_valid_q |-> req_ready, "ready low with empty output")

endmodule

/* sv/ealu_exec.sv */
`timescale 1ns / 1ps

module ealu_exec import ealu_pkg::*; (
	input  arch_t cur,
	input  req_t  item,
	output arch_t nxt,
	output rsp_t  res
);

	logic [7:0] m;
	logic [7:0] add_m;
	logic [8:0] sum;
	logic [7:0] cmp_reg;
	logic [8:0] diff;
	logic [7:0] r;

	assign m = item.operand;

	// Shared adder for ADC and SBC (SBC adds the inverted operand)
	assign add_m = (opcode_t'(item.opcode) == OP_SBC) ? ~m : m;
	assign sum   = {1'b0, cur.a} + {1'b0, add_m} + {8'd0, cur.c};

	// Shared subtractor for the compares
	always_comb begin
		unique case (opcode_t'(item.opcode))
			OP_CPX:  cmp_reg = cur.x;
			OP_CPY:  cmp_reg = cur.y;
			default: cmp_reg = cur.a;
		endcase
	end
	assign diff = {1'b0, cmp_reg} - {1'b0, m};

	// Operation select and state update
	always_comb begin
		nxt = cur;
		r   = m;
		unique case (opcode_t'(item.opcode))
			OP_ADC, OP_SBC: begin
				r     = sum[7:0];
				nxt.a = sum[7:0];
				nxt.c = sum[8];
				nxt.v = (cur.a[7] ^ sum[7]) & (add_m[7] ^ sum[7]);
			end
			OP_AND: begin
				r     = cur.a & m;
				nxt.a = r;
			end
			OP_ORA: begin
				r     = cur.a | m;
				nxt.a = r;
			end
			OP_EOR: begin
				r     = cur.a ^ m;
				nxt.a = r;
			end
			OP_BIT: begin
				r = cur.a & m;
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				r     = diff[7:0];
				nxt.c = ~diff[8];
			end
			OP_ASL: begin
				r     = {m[6:0], 1'b0};
				nxt.c = m[7];
			end
			OP_LSR: begin
				r     = {1'b0, m[7:1]};
				nxt.c = m[0];
			end
			OP_ROL: begin
				r     = {m[6:0], cur.c};
				nxt.c = m[7];
			end
			OP_ROR: begin
				r     = {cur.c, m[7:1]};
				nxt.c = m[0];
			end
			OP_LDA: nxt.a = m;
			OP_LDX: nxt.x = m;
			OP_LDY: nxt.y = m;
		endcase

		// Z and N: BIT takes N and V from the operand, all others from the byte
		nxt.z = (r == BYTE_ZERO);
		if (opcode_t'(item.opcode) == OP_BIT) begin
			nxt.n = m[7];
			nxt.v = m[6];
		end else begin
			nxt.n = r[7];
		end
	end

	assign res.result_byte  = r;
	assign res.carry_out    = nxt.c;
	assign res.zero_out     = nxt.z;
	assign res.overflow_out = nxt.v;
	assign res.negative_out = nxt.n;

endmodule

/* sv/ealu_state.sv */
`timescale 1ns / 1ps

module ealu_state import ealu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  arch_t nxt,
	output arch_t cur
);

	arch_t state_q;

	// A, X, Y and flags, written once per executed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (en) begin
			state_q <= nxt;
		end
	end

	assign cur = state_q;

endmodule
